FILE: hdl/abds_pkg.sv
// Shared types, constants and the rounding multiply for the deviatoric stress pipeline.
package abds_pkg;

    // Q16.16 word and the six-component symmetric tensor (xx, yy, zz, xy, yz, xz)
    typedef logic signed [31:0] q16_t;
    typedef logic [5:0][31:0] tensor_t;

    // Configuration register indexes
    typedef enum logic {
        REG_SHEAR_MODULUS = 1'b0,
        REG_CHAIN_LINKS   = 1'b1
    } cfg_reg_t;

    localparam logic [30:0] SHEAR_MODULUS_RST = 31'd65536;
    localparam logic [30:0] CHAIN_LINKS_RST   = 31'd524288;

    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    // Series coefficients, index = power of x
    localparam q16_t COEF [5] = '{32'sd32768, 32'sd6554, 32'sd2060, 32'sd712, 32'sd252};

    // Divider: quotient bits, and latency from input to result register
    localparam int DIV_QW  = 32;
    localparam int DIV_LAT = DIV_QW + 2;

    // Horner steps plus W1 and tensor scaling stages
    localparam int HORN_STEPS = 4;
    localparam int HORN_LAT   = HORN_STEPS + 2;

    // Operand widths
    localparam int X_NW  = 49;   // |I1| * 2^16
    localparam int X_DW  = 31;   // N
    localparam int S_NW  = 51;   // |2 * (3T - tr)| * 2^16
    localparam int S_DW  = 33;   // 3J
    localparam int BJ_W  = 6 * 32 + 31;

    // sat(floor((a*b + 2^15) / 2^16) + c)
    function automatic q16_t rmul_sat(input q16_t a, input q16_t b, input q16_t c);
        logic signed [63:0] prod;
        logic signed [64:0] rnd;
        logic signed [49:0] sum;
        q16_t               res;
        prod = 64'(a) * 64'(b);
        rnd  = 65'(prod) + 65'sd32768;
        sum  = 50'($signed(rnd[64:16])) + 50'(c);
        if (sum > 50'sd2147483647)
            res = Q_MAX;
        else if (sum < -50'sd2147483648)
            res = Q_MIN;
        else
            res = sum[31:0];
        return res;
    endfunction

endpackage

FILE: hdl/arruda_boyce_dev_stress.sv
// Top level: Arruda-Boyce deviatoric Cauchy stress, one material point per cycle unless m_axis stalls.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        b_xx..b_xz, volume_ratio
//  m_axis    out  m_axis_tvalid/tready        s_xx..s_xz
//  cfg       in   cfg_we                      cfg_index, cfg_data
//
// One word enters per cycle unless m_axis stalls; the pipeline is built around the two
// bit-per-stage dividers (x = I1/N, and the 2/J scaling), 34 stages each.
// Reset clears all valid bits and loads mu = 1.0, N = 8.0.
// A stall on m_axis freezes the whole pipeline; the final divider stage is the
// output register, so s_axis_tready follows m_axis_tready when the output is full.
module arruda_boyce_dev_stress import abds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // b_xx, b_yy, b_zz, b_xy, b_yz, b_xz, volume_ratio, zero pad
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // s_xx, s_yy, s_zz, s_xy, s_yz, s_xz
    output logic [191:0] m_axis_tdata
);

    logic [30:0] shear_modulus_reg;
    logic [30:0] chain_links_reg;
    logic        en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shear_modulus_reg <= SHEAR_MODULUS_RST;
            chain_links_reg   <= CHAIN_LINKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SHEAR_MODULUS: shear_modulus_reg <= cfg_data;
                REG_CHAIN_LINKS:   chain_links_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input stage: trace and its magnitude
    tensor_t            b_in;
    logic [30:0]        j_in;
    logic signed [33:0] i1;
    tensor_t            b0_reg;
    logic [30:0]        j0_reg;
    logic               neg0_reg;
    logic [32:0]        mag0_reg;
    logic               v0_reg;

    assign b_in = s_axis_tdata[191:0];
    assign j_in = s_axis_tdata[222:192];
    assign i1   = 34'($signed(b_in[0])) + 34'($signed(b_in[1])) + 34'($signed(b_in[2]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg   <= b_in;
            j0_reg   <= (j_in == '0) ? 31'd1 : j_in;
            neg0_reg <= i1[33];
            mag0_reg <= i1[33] ? 33'(-i1) : 33'(i1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_axis_tvalid;
    end

    // x = I1 / N
    logic [X_DW-1:0] n_den;
    logic            vx;
    logic [0:0][31:0] x_res;
    logic [BJ_W-1:0] bj_dly;

    assign n_den = (chain_links_reg == '0) ? 31'd1 : chain_links_reg;

    abds_div #(.LANES(1), .NW(X_NW), .DW(X_DW)) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (v0_reg),
        .in_neg  (neg0_reg),
        .in_mag  ({mag0_reg, 16'b0}),
        .in_den  (n_den),
        .out_vld (vx),
        .out_res (x_res)
    );

    abds_delay #(.WIDTH(BJ_W), .DEPTH(DIV_LAT)) u_dly_bj (
        .clk  (clk),
        .en   (en),
        .din  ({j0_reg, b0_reg}),
        .dout (bj_dly)
    );

    // W1 series and tensor scaling
    logic        vt;
    tensor_t     t;
    logic [30:0] jt;

    abds_horner u_horner (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vx),
        .x       ($signed(x_res[0])),
        .b       (bj_dly[191:0]),
        .j       (bj_dly[BJ_W-1:192]),
        .mu      (shear_modulus_reg),
        .out_vld (vt),
        .t       (t),
        .out_j   (jt)
    );

    // numerators 2*(3T - tr)*2^16 and 2*T*2^16, divisors 3J and J
    logic signed [33:0]     tr;
    logic [5:0]             sn_neg;
    logic [5:0][S_NW-1:0]   sn_mag;
    logic [5:0][S_DW-1:0]   sn_den;
    logic [5:0]             num_neg_reg;
    logic [5:0][S_NW-1:0]   num_mag_reg;
    logic [5:0][S_DW-1:0]   num_den_reg;
    logic                   vn_reg;

    assign tr = 34'($signed(t[0])) + 34'($signed(t[1])) + 34'($signed(t[2]));

    always_comb
    begin
        logic signed [34:0] v;
        logic signed [31:0] tk;
        for (int k = 0; k < 3; k++)
        begin
            v         = 35'($signed(t[k])) * 35'sd3 - 35'(tr);
            sn_neg[k] = v[34];
            sn_mag[k] = {(v[34] ? 34'(-v) : 34'(v)), 17'b0};
            sn_den[k] = {2'b0, jt} + {1'b0, jt, 1'b0};
        end
        for (int k = 3; k < 6; k++)
        begin
            tk        = $signed(t[k]);
            sn_neg[k] = tk[31];
            sn_mag[k] = {2'b0, (tk[31] ? 32'(-tk) : 32'(tk)), 17'b0};
            sn_den[k] = {2'b0, jt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_neg_reg <= sn_neg;
            num_mag_reg <= sn_mag;
            num_den_reg <= sn_den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg <= 1'b0;
        else if (en)
            vn_reg <= vt;
    end

    // final division; its last stage is the output register
    logic [5:0][31:0] s_res;

    abds_div #(.LANES(6), .NW(S_NW), .DW(S_DW)) u_div_s (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vn_reg),
        .in_neg  (num_neg_reg),
        .in_mag  (num_mag_reg),
        .in_den  (num_den_reg),
        .out_vld (m_axis_tvalid),
        .out_res (s_res)
    );

    assign m_axis_tdata = s_res;

endmodule

FILE: hdl/abds_delay.sv
// Enable-gated register line that carries side data alongside a pipelined unit.
module abds_delay import abds_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // shift on every advance of the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
                line_reg[k] <= line_reg[k-1];
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

FILE: hdl/abds_div.sv
// Pipelined restoring divider lanes: signed magnitude / positive divisor, rounded, saturated.
module abds_div import abds_pkg::*;
#(
    parameter int LANES = 1,
    parameter int NW    = 49,
    parameter int DW    = 31
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [LANES-1:0]           in_neg,
    input  logic [LANES-1:0][NW-1:0]   in_mag,
    input  logic [LANES-1:0][DW-1:0]   in_den,
    output logic                       out_vld,
    output logic [LANES-1:0][31:0]     out_res
);

    localparam int RW = (NW + 1 > DW + DIV_QW) ? NW + 1 : DW + DIV_QW;

    logic              vld_reg [DIV_QW+1];
    logic              out_vld_reg;

    // valid bits walk with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_QW; k++)
                vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= DIV_QW; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_vld_reg <= vld_reg[DIV_QW];
        end
    end

    assign out_vld = out_vld_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [RW-1:0]     rem_reg [DIV_QW+1];
        logic [DIV_QW-1:0] quo_reg [DIV_QW+1];
        logic [DW-1:0]     den_reg [DIV_QW+1];
        logic              neg_reg [DIV_QW+1];
        logic              ovf_reg [DIV_QW+1];
        logic [31:0]       res_reg;
        logic [RW-1:0]     rnd_num;
        logic [RW-1:0]     den_top;

        // add half the divisor, flag quotients of 2^32 or more
        assign rnd_num = RW'(in_mag[l]) + RW'(in_den[l] >> 1);
        assign den_top = RW'(in_den[l]) << DIV_QW;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0] <= rnd_num;
                quo_reg[0] <= '0;
                den_reg[0] <= in_den[l];
                neg_reg[0] <= in_neg[l];
                ovf_reg[0] <= (rnd_num >= den_top);
            end
        end

        // one quotient bit per stage, most significant first
        for (genvar k = 1; k <= DIV_QW; k++)
        begin : g_step
            localparam int BIT = DIV_QW - k;
            logic [RW-1:0] trial;
            logic          ge;

            assign trial = RW'(den_reg[k-1]) << BIT;
            assign ge    = (rem_reg[k-1] >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - trial : rem_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1] | (DIV_QW'(ge) << BIT);
                    den_reg[k] <= den_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end

        // apply sign and clamp
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                priority if (ovf_reg[DIV_QW])
                    res_reg <= neg_reg[DIV_QW] ? Q_MIN : Q_MAX;
                else if (!neg_reg[DIV_QW])
                    res_reg <= quo_reg[DIV_QW][31] ? Q_MAX : quo_reg[DIV_QW];
                else if (quo_reg[DIV_QW] > 32'h8000_0000)
                    res_reg <= Q_MIN;
                else
                    res_reg <= 32'(-quo_reg[DIV_QW]);
            end
        end

        assign out_res[l] = res_reg;
    end

endmodule

FILE: hdl/abds_horner.sv
// Horner series for W1, then scaling of the tensor by W1.
module abds_horner import abds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  q16_t        x,
    input  tensor_t     b,
    input  logic [30:0] j,
    input  logic [30:0] mu,
    output logic        out_vld,
    output tensor_t     t,
    output logic [30:0] out_j
);

    q16_t        p_reg [HORN_STEPS];
    q16_t        x_reg [HORN_STEPS];
    tensor_t     b_reg [HORN_STEPS];
    logic [30:0] j_reg [HORN_STEPS];
    logic        v_reg [HORN_STEPS];

    for (genvar h = 0; h < HORN_STEPS; h++)
    begin : g_step
        q16_t        p_src;
        q16_t        x_src;
        tensor_t     b_src;
        logic [30:0] j_src;
        logic        v_src;

        if (h == 0)
        begin : g_first
            assign p_src = COEF[HORN_STEPS];
            assign x_src = x;
            assign b_src = b;
            assign j_src = j;
            assign v_src = in_vld;
        end
        else
        begin : g_next
            assign p_src = p_reg[h-1];
            assign x_src = x_reg[h-1];
            assign b_src = b_reg[h-1];
            assign j_src = j_reg[h-1];
            assign v_src = v_reg[h-1];
        end

        // p = sat(rmul(p, x) + a_k)
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[h] <= rmul_sat(p_src, x_src, COEF[HORN_STEPS-1-h]);
                x_reg[h] <= x_src;
                b_reg[h] <= b_src;
                j_reg[h] <= j_src;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[h] <= 1'b0;
            else if (en)
                v_reg[h] <= v_src;
        end
    end

    q16_t        w1_reg;
    tensor_t     bw_reg;
    logic [30:0] jw_reg;
    logic        vw_reg;
    tensor_t     t_reg;
    logic [30:0] jt_reg;
    logic        vt_reg;

    // W1 = mu * p, then T = W1 * B
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= rmul_sat($signed({1'b0, mu}), p_reg[HORN_STEPS-1], '0);
            bw_reg <= b_reg[HORN_STEPS-1];
            jw_reg <= j_reg[HORN_STEPS-1];
            for (int k = 0; k < 6; k++)
                t_reg[k] <= rmul_sat(w1_reg, $signed(bw_reg[k]), '0);
            jt_reg <= jw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= 1'b0;
            vt_reg <= 1'b0;
        end
        else if (en)
        begin
            vw_reg <= v_reg[HORN_STEPS-1];
            vt_reg <= vw_reg;
        end
    end

    assign out_vld = vt_reg;
    assign t       = t_reg;
    assign out_j   = jt_reg;

endmodule
